// ----- src/bpcs_pkg.sv -----
`default_nettype none

package bpcs_pkg;

  // Width of the window and idle timers; both saturate at all ones
  localparam int unsigned TimerBits = 16;

  // Width used when timers are compared against 16-bit registers
  localparam int unsigned CmpBits = (TimerBits > 16) ? TimerBits : 16;

  localparam int unsigned DebBits   = 8;
  localparam int unsigned WinBits   = 16;
  localparam int unsigned IdleBits  = 16;
  localparam int unsigned CountBits = 3;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned InDataBits  = 8;
  localparam int unsigned OutDataBits = 8;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxBits-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_WINDOW   = 2'd1,
    REG_IDLE     = 2'd2,
    REG_MAXCNT   = 2'd3
  } reg_idx_e;

  // Reset values of the configuration registers
  localparam logic [DebBits-1:0]   DebounceReset = 8'd4;
  localparam logic [WinBits-1:0]   WindowReset   = 16'd400;
  localparam logic [IdleBits-1:0]  IdleReset     = 16'd160;
  localparam logic [CountBits-1:0] MaxCountReset = 3'd5;

  typedef struct packed {
    logic [DebBits-1:0]   debounce_ticks;
    logic [WinBits-1:0]   window_ticks;
    logic [IdleBits-1:0]  confirm_idle_ticks;
    logic [CountBits-1:0] max_count;
  } cfg_t;

  typedef struct packed {
    logic                 done_res;
    logic                 selecting;
    logic [CountBits-1:0] selected_count;
  } result_t;

endpackage

`default_nettype wire

// ----- src/button_press_count_selector_unit.sv -----
// Each accepted input word's result word is registered in the output register.
// Throughput: one word per cycle; input ready whenever the output register is empty or
// is being drained in the same cycle.
// Reset (rst_ni low, asynchronous): configuration returns to its defaults, the selector
// waits for release with a zero count, and the output register is emptied.
`default_nettype none

module button_press_count_selector_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration write port
  input  wire logic                                 cfg_we_i,
  input  wire logic [bpcs_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  wire logic [bpcs_pkg::CfgDataBits-1:0]     cfg_wdata_i,
  // input stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [bpcs_pkg::InDataBits-1:0]      s_axis_tdata,  // [0] button_level
  // result stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [bpcs_pkg::OutDataBits-1:0]          m_axis_tdata   // [2:0] selected_count,
                                                                   // [3] selecting,
                                                                   // [4] done_res
);

  bpcs_pkg::cfg_t    cfg;
  bpcs_pkg::result_t res;
  logic              free;
  logic              accept;

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;

  bpcs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bpcs_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (accept),
    .level_i (s_axis_tdata[0]),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  bpcs_out_reg u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (accept),
    .res_i     (res),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (m_axis_tdata),
    .free_o    (free)
  );

`ifndef SYNTHESIS
  // a confirmed selection has closed its window
  a_done_not_selecting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[4]) |-> !m_axis_tdata[3])
    else $error("done word still reports selecting");

  // an open window always holds a count of at least one
  a_selecting_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[3]) |-> (m_axis_tdata[2:0] != 3'd0))
    else $error("selecting with zero count");

  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // an accepted word always shows up in the output register
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted word lost");
`endif

endmodule

`default_nettype wire

// ----- src/bpcs_cfg_regs.sv -----
`default_nettype none

module bpcs_cfg_regs (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [bpcs_pkg::CfgIdxBits-1:0]        cfg_idx_i,
  input  wire logic [bpcs_pkg::CfgDataBits-1:0]       cfg_wdata_i,
  output bpcs_pkg::cfg_t                              cfg_o
);

  bpcs_pkg::cfg_t cfg_q;

  // register file, one write per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks     <= bpcs_pkg::DebounceReset;
      cfg_q.window_ticks       <= bpcs_pkg::WindowReset;
      cfg_q.confirm_idle_ticks <= bpcs_pkg::IdleReset;
      cfg_q.max_count          <= bpcs_pkg::MaxCountReset;
    end else if (cfg_we_i) begin
      unique case (bpcs_pkg::reg_idx_e'(cfg_idx_i))
        bpcs_pkg::REG_DEBOUNCE: begin
          cfg_q.debounce_ticks <= cfg_wdata_i[bpcs_pkg::DebBits-1:0];
        end
        bpcs_pkg::REG_WINDOW: begin
          cfg_q.window_ticks <= cfg_wdata_i[bpcs_pkg::WinBits-1:0];
        end
        bpcs_pkg::REG_IDLE: begin
          cfg_q.confirm_idle_ticks <= cfg_wdata_i[bpcs_pkg::IdleBits-1:0];
        end
        bpcs_pkg::REG_MAXCNT: begin
          cfg_q.max_count <= cfg_wdata_i[bpcs_pkg::CountBits-1:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- src/bpcs_core.sv -----
`default_nettype none

module bpcs_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic             level_i,
  input  wire bpcs_pkg::cfg_t   cfg_i,
  output bpcs_pkg::result_t     res_o
);

  localparam int unsigned TB = bpcs_pkg::TimerBits;
  localparam int unsigned CB = bpcs_pkg::CmpBits;
  localparam logic [TB-1:0] TimerMax = {TB{1'b1}};

  typedef enum logic [1:0] {
    PH_WAIT_RELEASE,
    PH_WAIT_PRESS,
    PH_FIRST_DEBOUNCE,
    PH_SELECT
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [bpcs_pkg::CountBits-1:0]  count_q, count_d;
  logic                            was_pressed_q, was_pressed_d;
  logic [TB-1:0]                   win_q, win_d;
  logic [TB-1:0]                   idle_q, idle_d;
  logic [bpcs_pkg::DebBits-1:0]    deb_q, deb_d;

  logic [bpcs_pkg::DebBits-1:0]    eff_deb;
  logic [bpcs_pkg::CountBits-1:0]  eff_max;
  logic [bpcs_pkg::DebBits-1:0]    deb_dec;
  logic [TB-1:0]                   win_inc;
  logic [TB-1:0]                   idle_inc;
  logic                            end_w;

  function automatic logic [TB-1:0] sat_inc(input logic [TB-1:0] v);
    return (v == TimerMax) ? TimerMax : v + 1'b1;
  endfunction

  // zero settings behave as one
  assign eff_deb = (cfg_i.debounce_ticks == '0) ? bpcs_pkg::DebBits'(1)
                                                : cfg_i.debounce_ticks;
  assign eff_max = (cfg_i.max_count == '0) ? bpcs_pkg::CountBits'(1) : cfg_i.max_count;
  assign deb_dec  = (deb_q != '0) ? deb_q - 1'b1 : deb_q;
  assign win_inc  = sat_inc(win_q);
  assign idle_inc = sat_inc(idle_q);

  // next state for one tick
  always_comb begin
    phase_d       = phase_q;
    count_d       = count_q;
    was_pressed_d = was_pressed_q;
    win_d         = win_q;
    idle_d        = idle_q;
    deb_d         = deb_q;
    end_w         = 1'b0;

    unique case (phase_q)
      PH_WAIT_RELEASE: begin
        if (!level_i) phase_d = PH_WAIT_PRESS;
      end
      PH_WAIT_PRESS: begin
        if (level_i) begin
          deb_d   = eff_deb;
          phase_d = PH_FIRST_DEBOUNCE;
        end
      end
      PH_FIRST_DEBOUNCE: begin
        deb_d = deb_dec;
        if (deb_dec == '0) begin
          if (level_i) begin
            count_d       = bpcs_pkg::CountBits'(1);
            was_pressed_d = 1'b1;
            win_d         = '0;
            idle_d        = '0;
            phase_d       = PH_SELECT;
          end else begin
            phase_d = PH_WAIT_PRESS;
          end
        end
      end
      PH_SELECT: begin
        if (deb_q != '0) begin
          // re-sample pending: button ignored until the count hits zero
          deb_d = deb_dec;
          if (deb_dec == '0 && level_i) begin
            if (count_q < eff_max) count_d = count_q + 1'b1;
            was_pressed_d = 1'b1;
            idle_d        = '0;
          end
        end else if (level_i && !was_pressed_q) begin
          deb_d = eff_deb;
        end else if (!level_i) begin
          was_pressed_d = 1'b0;
          idle_d        = idle_inc;
          if (CB'(idle_inc) >= CB'(cfg_i.confirm_idle_ticks)) end_w = 1'b1;
        end else begin
          idle_d = '0;
        end
        // window time runs on every selecting tick not closed by the idle check
        if (!end_w) begin
          win_d = win_inc;
          if (CB'(win_inc) >= CB'(cfg_i.window_ticks) || win_inc == TimerMax) begin
            end_w = 1'b1;
          end
        end
      end
      default: begin
        phase_d = PH_WAIT_RELEASE;
      end
    endcase

    res_o.selected_count = count_d;
    res_o.done_res       = end_w;

    // re-arm after confirm
    if (end_w) begin
      phase_d       = PH_WAIT_RELEASE;
      count_d       = '0;
      was_pressed_d = 1'b0;
      deb_d         = '0;
    end

    res_o.selecting = (phase_d == PH_SELECT);
  end

  // state advances once per accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_WAIT_RELEASE;
      count_q       <= '0;
      was_pressed_q <= 1'b0;
      win_q         <= '0;
      idle_q        <= '0;
      deb_q         <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      count_q       <= count_d;
      was_pressed_q <= was_pressed_d;
      win_q         <= win_d;
      idle_q        <= idle_d;
      deb_q         <= deb_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/bpcs_out_reg.sv -----
`default_nettype none

module bpcs_out_reg (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 load_i,
  input  wire bpcs_pkg::result_t                    res_i,
  input  wire logic                                 m_ready_i,
  output logic                                      m_valid_o,
  output logic [bpcs_pkg::OutDataBits-1:0]          m_data_o,
  output logic                                      free_o
);

  logic              valid_q;
  bpcs_pkg::result_t res_q;

  // slot is free when empty or drained this cycle
  assign free_o = !valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = bpcs_pkg::OutDataBits'(res_q);

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import bpcs_pkg::*;

  // Phases of the selection flow
  typedef enum logic [1:0] {
    PH_WAIT_RELEASE,
    PH_WAIT_PRESS,
    PH_FIRST_DEBOUNCE,
    PH_SELECT
  } sel_phase_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx_i     = '0;
  logic [CfgDataBits-1:0] cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata  = '0;  // [0] button_level
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;        // [2:0] selected_count, [3] selecting,
                                               // [4] done_res

  button_press_count_selector_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predictor configuration, mirrors the register file
  logic [DebBits-1:0]   cfg_settle = DebounceReset;
  logic [WinBits-1:0]   cfg_window = WindowReset;
  logic [IdleBits-1:0]  cfg_idle   = IdleReset;
  logic [CountBits-1:0] cfg_limit  = MaxCountReset;

  // Predictor state
  sel_phase_e           sel_phase   = PH_WAIT_RELEASE;
  logic [CountBits-1:0] tally       = '0;
  logic                 held_seen   = 1'b0;
  logic [TimerBits-1:0] win_count   = '0;
  logic [TimerBits-1:0] idle_count  = '0;
  logic [DebBits-1:0]   settle_left = '0;

  result_t expected_selections[$];

  int src_gap_pct  = 0;
  int sink_gap_pct = 0;
  int hold_left    = 0;
  int fault_count  = 0;
  int ticks_sent   = 0;
  int words_checked = 0;
  int selections_confirmed = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("button_press_count_selector_unit regression: fail");
    $finish;
  end

  function automatic logic [DebBits-1:0] eff_settle();
    return (cfg_settle == '0) ? DebBits'(1) : cfg_settle;
  endfunction

  function automatic logic [CountBits-1:0] eff_limit();
    return (cfg_limit == '0) ? CountBits'(1) : cfg_limit;
  endfunction

  function automatic logic [TimerBits-1:0] bump(input logic [TimerBits-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Advance the selector by one tick and return the word it shows
  function automatic result_t next_selection(input logic lvl);
    logic    closes;
    result_t r;
    closes = 1'b0;
    case (sel_phase)
      PH_WAIT_RELEASE: begin
        if (!lvl) sel_phase = PH_WAIT_PRESS;
      end
      PH_WAIT_PRESS: begin
        if (lvl) begin
          settle_left = eff_settle();
          sel_phase   = PH_FIRST_DEBOUNCE;
        end
      end
      PH_FIRST_DEBOUNCE: begin
        if (settle_left != '0) settle_left = settle_left - 1'b1;
        if (settle_left == '0) begin
          if (lvl) begin
            tally      = CountBits'(1);
            held_seen  = 1'b1;
            win_count  = '0;
            idle_count = '0;
            sel_phase  = PH_SELECT;
          end else begin
            sel_phase = PH_WAIT_PRESS;
          end
        end
      end
      default: begin
        if (settle_left != '0) begin
          // re-sample only when the debounce wait runs out
          settle_left = settle_left - 1'b1;
          if (settle_left == '0 && lvl) begin
            if (tally < eff_limit()) tally = tally + 1'b1;
            held_seen  = 1'b1;
            idle_count = '0;
          end
        end else if (lvl && !held_seen) begin
          settle_left = eff_settle();
        end else if (!lvl) begin
          held_seen  = 1'b0;
          idle_count = bump(idle_count);
          if (idle_count >= cfg_idle) closes = 1'b1;
        end else begin
          idle_count = '0;
        end
        if (!closes) begin
          win_count = bump(win_count);
          if (win_count >= cfg_window || win_count == '1) closes = 1'b1;
        end
      end
    endcase
    r.selected_count = tally;
    if (closes) begin
      sel_phase   = PH_WAIT_RELEASE;
      tally       = '0;
      held_seen   = 1'b0;
      settle_left = '0;
    end
    r.selecting = (sel_phase == PH_SELECT);
    r.done_res  = closes;
    return r;
  endfunction

  // Result sink: random stalls, or a counted hold-off when requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_gap_pct);
    end
  end

  // Compare every accepted result word with the oldest prediction
  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[4:0]);
      words_checked++;
      if (expected_selections.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: unexpected word: count %0d selecting %0b done %0b",
                   $time, got.selected_count, got.selecting, got.done_res);
      end else begin
        want = expected_selections.pop_front();
        if (got.selected_count !== want.selected_count || got.selecting !== want.selecting ||
            got.done_res !== want.done_res) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("%0t: mismatch: expected count %0d selecting %0b done %0b,",
                     $time, want.selected_count, want.selecting, want.done_res);
            $display("    got count %0d selecting %0b done %0b",
                     got.selected_count, got.selecting, got.done_res);
          end
        end
      end
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataBits-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_DEBOUNCE: cfg_settle = val[DebBits-1:0];
      REG_WINDOW:   cfg_window = val[WinBits-1:0];
      REG_IDLE:     cfg_idle   = val[IdleBits-1:0];
      default:      cfg_limit  = val[CountBits-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input int deb, input int win, input int idl, input int mx);
    write_reg(REG_DEBOUNCE, CfgDataBits'(deb));
    write_reg(REG_WINDOW, CfgDataBits'(win));
    write_reg(REG_IDLE, CfgDataBits'(idl));
    write_reg(REG_MAXCNT, CfgDataBits'(mx));
  endtask

  // Offer one tick word; valid stays high afterwards until the next call or a drain
  task automatic send_tick(input logic lvl);
    result_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataBits-1){1'b0}}, lvl};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = next_selection(lvl);
    expected_selections.push_back(r);
    ticks_sent++;
    if (r.done_res) selections_confirmed++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_selections.size() != 0) @(posedge clk_i);
  endtask

  // Levels are sent from the highest bit down
  task automatic send_levels(input logic [31:0] pattern, input int n);
    for (int i = n - 1; i >= 0; i--) send_tick(pattern[i]);
    wait_drained();
  endtask

  // Zero debounce and zero maximum, saturated count, idle confirm
  task automatic test_debounce_and_saturation();
    set_config(0, 20, 3, 0);
    send_levels(32'b1011011000, 10);
  endtask

  // Failed debounce, zero window, zero idle confirm
  task automatic test_window_and_idle_zero();
    set_config(2, 0, 0, 7);
    send_levels(32'b0100111101110, 13);
  endtask

  // Window closes while a later press is still debouncing
  task automatic test_debounce_outlasts_window();
    set_config(3, 3, 5, 3);
    send_levels(32'b01111011, 8);
  endtask

  // Press/release bursts sized around the current debounce and idle settings
  task automatic test_random_traffic(input int n_items);
    int   deb, win, idl, mx, eff, idle_span, run_left, roll;
    logic lvl;
    for (int seg = 0; seg < n_items / 60; seg++) begin
      deb  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
      roll = $urandom_range(9);
      win  = (roll == 0) ? 0 : (roll == 1) ? 65535 : $urandom_range(1, 60);
      roll = $urandom_range(9);
      idl  = (roll == 0) ? 0 : (roll == 1) ? 65535 : $urandom_range(1, 20);
      mx   = $urandom_range(7);
      set_config(deb, win, idl, mx);
      eff       = (deb == 0) ? 1 : deb;
      idle_span = (idl + 2 > 40) ? 40 : idl + 2;
      lvl       = 1'b1;
      run_left  = 0;
      for (int i = 0; i < 60; i++) begin
        if (run_left == 0) begin
          // mostly clean alternation, sometimes a bounce of random level
          lvl = ($urandom_range(19) == 0) ? logic'($urandom_range(1)) : !lvl;
          if (lvl)
            run_left = ($urandom_range(9) < 7) ? $urandom_range(eff, eff + 4)
                                               : $urandom_range(1, eff);
          else
            run_left = ($urandom_range(9) < 6) ? $urandom_range(1, idle_span)
                                               : $urandom_range(1, 3);
        end
        send_tick(lvl);
        run_left--;
      end
      wait_drained();
    end
  endtask

  // Long sink hold-off while words keep coming, so the input backs up
  task automatic test_output_stall();
    set_config(1, 30, 4, 7);
    hold_left = 300;
    for (int i = 0; i < 60; i++) send_tick(logic'($urandom_range(1)));
    wait_drained();
  endtask

  // Largest window and idle: count saturates at 7 while the window stays open
  task automatic test_full_window();
    set_config(1, 65535, 65535, 7);
    for (int i = 0; i < 120; i++) send_tick((i % 4) >= 2);
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    src_gap_pct  = 31;
    sink_gap_pct = 81;
    test_debounce_and_saturation();
    test_window_and_idle_zero();
    test_debounce_outlasts_window();
    test_random_traffic(300);

    src_gap_pct  = 81;
    sink_gap_pct = 31;
    test_random_traffic(300);

    src_gap_pct  = 0;
    sink_gap_pct = 0;
    test_random_traffic(240);
    test_output_stall();
    test_full_window();

    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("Covered: directed debounce/window/idle corner cases, bursty press traffic");
    $display("under three stall patterns, a long output stall and the largest timer settings.");
    $display("%0d ticks sent, %0d words checked, %0d selections confirmed, %0d mismatches",
             ticks_sent, words_checked, selections_confirmed, fault_count);
    if (fault_count == 0 && expected_selections.size() == 0) begin
      $display("button_press_count_selector_unit regression: pass");
    end else begin
      $display("button_press_count_selector_unit regression: fail");
    end
    $finish;
  end

endmodule
